// ===== rtl/lur_pkg.sv =====
package lur_pkg;

	// Store depth and value word width
	localparam int MAX_ITEMS   = 1024;
	localparam int VALUE_WIDTH = 32;

	// Index and count widths follow from the depth
	localparam int ADDR_W = $clog2(MAX_ITEMS);
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

	// Result field widths are fixed by the stream format
	localparam int START_W = 10;
	localparam int LEN_W   = 11;

	// Stream data widths, padded to whole bytes
	localparam int IN_W  = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int OUT_W = ((START_W + LEN_W + 1 + 7) / 8) * 8;

	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [VALUE_WIDTH-1:0] value_t;

	// Request from the sequencer to the value store
	typedef struct packed {
		logic   wr_en;
		addr_t  wr_addr;
		value_t wr_data;
		logic   rd_en;
		addr_t  rd_addr;
	} store_req_t;

endpackage

// ===== rtl/longest_unique_run.sv =====
// longest_unique_run: finds the longest contiguous run of a value stream
// in which no value appears twice.
// Input stream (s_*): one signed value per request in s_tdata; s_tlast marks
// the final value of a sequence. Output stream (m_*): one result per
// sequence, sent after the request that carries s_tlast.
// Each value is written to a 1024-entry store and compared against the
// current window, oldest entry first, one store read per cycle through a
// single comparator. A request with an empty window needs no scan; otherwise
// the scan ends at the first repeat or at the end of the window. A last
// request then goes through a close state, which ends the run, and an emit
// state, which loads the result register.
// s_tready is high only in the idle state, so it is low while a value is
// being scanned and while a result is closed and emitted. The result sits
// in an output register, so a stalled receiver does not block new values;
// only the next result waits until the previous one has been taken.
// Values beyond the store depth are dropped and flagged in the result.
// Reset clears the sequence counters and the output valid; the store
// content needs no clearing since only entries written in the current
// sequence are read.
module longest_unique_run (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [lur_pkg::IN_W-1:0]    s_tdata,  // [31:0] value
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [lur_pkg::OUT_W-1:0]   m_tdata   // [9:0] run_start, [20:10] run_length,
	                                              // [21] overflow, [23:22] zero
);
	import lur_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_CLOSE = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t     state_q;
	cnt_t       item_count_q;
	addr_t      window_start_q;
	cnt_t       best_length_q;
	addr_t      best_end_q;
	logic       overflow_q;
	value_t     value_q;
	logic       last_q;
	addr_t      pos_q;
	addr_t      scan_idx_q;
	addr_t      cmp_idx_q;
	logic       cmp_valid_q;
	logic       m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	store_req_t store_req;
	value_t     rd_data;

	logic       accept;
	logic       store_full;
	value_t     in_value;
	logic       issue;
	logic       match;
	logic       scan_end;
	cnt_t       match_len;
	cnt_t       close_len;
	cnt_t       first_c;
	logic       out_free;

	lur_store u_store (
		.clk     (clk),
		.req     (store_req),
		.rd_data (rd_data)
	);

	// handshake and decode
	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign in_value   = s_tdata[VALUE_WIDTH-1:0];
	assign store_full = (item_count_q == CNT_W'(MAX_ITEMS));
	assign out_free   = !m_tvalid_q || m_tready;

	// scan datapath: one read issued, one compare per cycle
	assign issue     = (state_q == ST_SCAN) && (scan_idx_q < pos_q);
	assign match     = cmp_valid_q && (rd_data == value_q);
	assign scan_end  = cmp_valid_q && (match || (cmp_idx_q == pos_q - addr_t'(1)));
	assign match_len = {1'b0, pos_q} - {1'b0, window_start_q};
	assign close_len = item_count_q - {1'b0, window_start_q};
	assign first_c   = {1'b0, best_end_q} + cnt_t'(1) - best_length_q;

	always_comb begin
		store_req.wr_en   = accept && !store_full;
		store_req.wr_addr = item_count_q[ADDR_W-1:0];
		store_req.wr_data = in_value;
		store_req.rd_en   = issue;
		store_req.rd_addr = scan_idx_q;
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= in_value;
			last_q  <= s_tlast;
			pos_q   <= item_count_q[ADDR_W-1:0];
		end
	end

	// sequencer and run bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			item_count_q   <= '0;
			window_start_q <= '0;
			best_length_q  <= '0;
			best_end_q     <= '0;
			overflow_q     <= 1'b0;
			scan_idx_q     <= '0;
			cmp_idx_q      <= '0;
			cmp_valid_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cmp_valid_q <= 1'b0;
					if (accept) begin
						if (store_full) begin
							overflow_q <= 1'b1;
							state_q    <= s_tlast ? ST_CLOSE : ST_IDLE;
						end else begin
							item_count_q <= item_count_q + cnt_t'(1);
							scan_idx_q   <= window_start_q;
							if ({1'b0, window_start_q} < item_count_q) begin
								state_q <= ST_SCAN;
							end else begin
								state_q <= s_tlast ? ST_CLOSE : ST_IDLE;
							end
						end
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						cmp_valid_q <= 1'b0;
						if (match) begin
							if (match_len > best_length_q) begin
								best_length_q <= match_len;
								best_end_q    <= pos_q - addr_t'(1);
							end
							window_start_q <= cmp_idx_q + addr_t'(1);
						end
						state_q <= last_q ? ST_CLOSE : ST_IDLE;
					end else begin
						cmp_valid_q <= issue;
						cmp_idx_q   <= scan_idx_q;
						if (issue) begin
							scan_idx_q <= scan_idx_q + addr_t'(1);
						end
					end
				end
				ST_CLOSE: begin
					if (close_len > best_length_q) begin
						best_length_q <= close_len;
						best_end_q    <= ADDR_W'(item_count_q - cnt_t'(1));
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						item_count_q   <= '0;
						window_start_q <= '0;
						best_length_q  <= '0;
						best_end_q     <= '0;
						overflow_q     <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= OUT_W'({overflow_q, LEN_W'(best_length_q), START_W'(first_c)});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// window never runs past the stored items
	a_window_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, window_start_q} <= item_count_q)
		else $error("window start beyond item count");

	// best run never longer than what was stored
	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		best_length_q <= item_count_q)
		else $error("best length beyond item count");

	// a pending compare only lives in the scan state and stays inside the window
	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_valid_q |-> (state_q == ST_SCAN) && (cmp_idx_q < pos_q)
			&& (cmp_idx_q >= window_start_q))
		else $error("compare outside scan window");

	// a new result always reports a nonempty run
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free) |-> (best_length_q != '0))
		else $error("empty run reported");

	// no new value taken while a scan is in flight
	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> !$past(accept))
		else $error("value accepted during scan");

endmodule

// ===== rtl/lur_store.sv =====
module lur_store (
	input  logic                clk,
	input  lur_pkg::store_req_t req,
	output lur_pkg::value_t     rd_data
);
	import lur_pkg::*;

	value_t mem [MAX_ITEMS];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// ===== tb/longest_unique_run_tb.sv =====
`timescale 1ns / 100ps

module longest_unique_run_tb;
	import lur_pkg::*;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
		logic               ovf;
	} run_t;

	// One row of the directed script; typed rows carry their own result
	typedef struct packed {
		value_t v;
		logic   l;
		logic   typed;
		run_t   r;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tlast = 1'b0;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tready = 1'b0;
	wire s_tready;
	wire m_tvalid;
	wire [OUT_W-1:0] m_tdata;

	// Own copy of the sequence state
	value_t seen [MAX_ITEMS];
	cnt_t   held = '0;
	addr_t  win_lo = '0;
	cnt_t   best_len = '0;
	addr_t  best_last = '0;
	logic   dropped = 1'b0;

	run_t  runs_due [$];
	step_t script [$];
	int    mismatches = 0;
	int    sent = 0;
	int    gap_pct = 0;
	int    stall_left = 0;
	bit    calm = 1'b0;

	longest_unique_run DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hang guard
	initial begin
		#50_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic run_t make_run(input int s, input int len, input logic o);
		run_t r;
		r.start = START_W'(s);
		r.len   = LEN_W'(len);
		r.ovf   = o;
		return r;
	endfunction

	// Folds one value into the window; returns 1 with the result on last
	function automatic bit fold_value(input value_t v, input logic l, output run_t r);
		int pos;
		int k;
		pos = int'(held);
		r = '0;
		if (pos >= MAX_ITEMS) begin
			dropped = 1'b1;
		end else begin
			seen[pos] = v;
			// first equal entry, oldest first, closes the run before it
			for (k = int'(win_lo); k < pos; k++) begin
				if (seen[k] == v) begin
					if (pos - int'(win_lo) > int'(best_len)) begin
						best_len  = cnt_t'(pos - int'(win_lo));
						best_last = addr_t'(pos - 1);
					end
					win_lo = addr_t'(k + 1);
					break;
				end
			end
			held = cnt_t'(pos + 1);
		end
		if (!l)
			return 1'b0;
		// close the final run; ties keep the earlier one
		if (int'(held) - int'(win_lo) > int'(best_len)) begin
			best_len  = cnt_t'(int'(held) - int'(win_lo));
			best_last = addr_t'(int'(held) - 1);
		end
		r.start = START_W'(int'(best_last) + 1 - int'(best_len));
		r.len   = LEN_W'(best_len);
		r.ovf   = dropped;
		held      = '0;
		win_lo    = '0;
		best_len  = '0;
		best_last = '0;
		dropped   = 1'b0;
		return 1'b1;
	endfunction

	// Sends one request, with an optional idle burst ahead of it
	task automatic send_value(input value_t v, input logic l, input logic typed,
	                          input run_t typed_r);
		run_t r;
		if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		sent++;
		if (fold_value(v, l, r))
			runs_due.push_back(typed ? typed_r : r);
	endtask

	task automatic add_step(input value_t v, input logic l, input logic typed, input run_t r);
		step_t st;
		st.v = v;
		st.l = l;
		st.typed = typed;
		st.r = r;
		script.push_back(st);
	endtask

	// One random sequence; mostly small palettes so repeats are frequent
	task automatic send_random_run();
		value_t pal [16];
		int n;
		int pal_n;
		int i;
		value_t v;
		case ($urandom_range(0, 2))
			0: gap_pct = 0;
			1: gap_pct = 20;
			default: gap_pct = 50;
		endcase
		for (i = 0; i < 16; i++) begin
			if ($urandom_range(0, 2) == 0)
				pal[i] = value_t'(int'($urandom_range(0, 3)) - 2);
			else
				pal[i] = $urandom;
		end
		case ($urandom_range(0, 9))
			0: begin
				n = $urandom_range(1, 4);
				pal_n = 0;
			end
			1: begin
				n = $urandom_range(20, 60);
				pal_n = 16;
			end
			2: begin
				n = $urandom_range(2, 8);
				pal_n = 1;
			end
			default: begin
				n = $urandom_range(2, 12);
				pal_n = $urandom_range(2, 6);
			end
		endcase
		for (i = 0; i < n; i++) begin
			v = (pal_n == 0) ? value_t'($urandom) : pal[$urandom_range(0, pal_n - 1)];
			send_value(v, i == n - 1, 1'b0, '0);
		end
	endtask

	// Receiver stalls in random bursts
	always @(posedge clk) begin
		if (calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result checker
	always @(posedge clk) begin
		run_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (runs_due.size() == 0) begin
				$error("result with nothing pending: m_tdata=%h", m_tdata);
				mismatches++;
			end else begin
				want = runs_due.pop_front();
				if (m_tdata[START_W-1:0] !== want.start) begin
					$error("run_start: expected %0d, got %0d", want.start,
					       m_tdata[START_W-1:0]);
					mismatches++;
				end
				if (m_tdata[START_W +: LEN_W] !== want.len) begin
					$error("run_length: expected %0d, got %0d", want.len,
					       m_tdata[START_W +: LEN_W]);
					mismatches++;
				end
				if (m_tdata[START_W+LEN_W] !== want.ovf) begin
					$error("overflow: expected %0d, got %0d", want.ovf,
					       m_tdata[START_W+LEN_W]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int i;
		int rand_base;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single element, all-zero and most negative
		add_step(32'h0000_0000, 1'b1, 1'b1, make_run(0, 1, 1'b0));
		add_step(32'h8000_0000, 1'b1, 1'b1, make_run(0, 1, 1'b0));
		// equal-length later run loses the tie
		add_step(32'h7FFF_FFFF, 1'b0, 1'b0, '0);
		add_step(32'h8000_0000, 1'b0, 1'b0, '0);
		add_step(32'hFFFF_FFFF, 1'b0, 1'b0, '0);
		add_step(32'h0000_0000, 1'b0, 1'b0, '0);
		add_step(32'h7FFF_FFFF, 1'b1, 1'b0, '0);
		// all equal
		add_step(32'd5, 1'b0, 1'b0, '0);
		add_step(32'd5, 1'b0, 1'b0, '0);
		add_step(32'd5, 1'b1, 1'b1, make_run(0, 1, 1'b0));
		// longer run found after the first repeat
		add_step(32'd1, 1'b0, 1'b0, '0);
		add_step(32'd2, 1'b0, 1'b0, '0);
		add_step(32'd3, 1'b0, 1'b0, '0);
		add_step(32'd1, 1'b0, 1'b0, '0);
		add_step(32'd2, 1'b0, 1'b0, '0);
		add_step(32'd3, 1'b0, 1'b0, '0);
		add_step(32'd4, 1'b1, 1'b0, '0);
		// repeat matches in the middle of the window
		add_step(32'd1, 1'b0, 1'b0, '0);
		add_step(32'd2, 1'b0, 1'b0, '0);
		add_step(32'd3, 1'b0, 1'b0, '0);
		add_step(32'd2, 1'b1, 1'b0, '0);

		gap_pct = 30;
		foreach (script[j])
			send_value(script[j].v, script[j].l, script[j].typed, script[j].r);

		// whole store distinct: longest possible run
		gap_pct = 5;
		for (i = 0; i < MAX_ITEMS; i++)
			send_value(32'hA500_0000 ^ value_t'(i), i == MAX_ITEMS - 1,
			           i == MAX_ITEMS - 1, make_run(0, MAX_ITEMS, 1'b0));

		// store full, closing request itself dropped
		for (i = 0; i < MAX_ITEMS + 3; i++)
			send_value(value_t'(i % 5), i == MAX_ITEMS + 2, 1'b0, '0);

		// random sequences; no idling near the end
		rand_base = sent;
		while (sent - rand_base < 450) begin
			calm = (sent - rand_base > 370);
			send_random_run();
		end
		s_tvalid <= 1'b0;

		while (runs_due.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
